### hw/rtl/rwdl_pkg.sv
// Shared types and constants for the register write delta logger.
package rwdl_pkg;

	localparam int MAX_BYTES = 7;
	localparam int CNT_W     = 3;

	// access kind on the input side
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// result kind on the output side
	localparam logic KIND_LOG  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// delta escape bytes
	localparam logic [7:0]  ESC16   = 8'hFE;
	localparam logic [7:0]  ESC32   = 8'hFF;
	localparam logic [31:0] D16_MAX = 32'h0000_FFFF;

	// record lengths
	localparam logic [CNT_W-1:0] LEN_READ  = 3'd1;
	localparam logic [CNT_W-1:0] LEN_SHORT = 3'd3;
	localparam logic [CNT_W-1:0] LEN_D16   = 3'd5;
	localparam logic [CNT_W-1:0] LEN_D32   = 3'd7;

	// one item's worth of output bytes, byte 0 goes out first
	typedef struct packed {
		logic                          kind;
		logic [CNT_W-1:0]              cnt;
		logic [MAX_BYTES-1:0][7:0]     bytes;
	} rec_t;

endpackage

### hw/rtl/rwdl_shadow.sv
// Shadow register file: synchronous RAM with valid bits and write forwarding.
module rwdl_shadow #(
	parameter int REG_COUNT = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(REG_COUNT)-1:0] rd_addr,
	output logic [7:0]                   rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(REG_COUNT)-1:0] wr_addr,
	input  logic [7:0]                   wr_data
);
	logic [7:0]           mem [REG_COUNT];
	logic [REG_COUNT-1:0] valid_q;
	logic [7:0]           mem_q;
	logic                 vld_q;
	logic                 fwd_q;
	logic [7:0]           fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q      <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_q   <= 1'b0;
			fwd_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_q <= valid_q[rd_addr];
				// write to the same entry in the read cycle: RAM returns stale data
				fwd_q <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : (vld_q ? mem_q : 8'h00);

endmodule

### hw/rtl/rwdl_emit.sv
// Output record register and byte serializer for the log stream.
module rwdl_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  rwdl_pkg::rec_t rec,
	output logic          can_load,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [7:0]    m_axis_tdata,  // [7:0] result_byte
	output logic          m_axis_tuser,  // [0] result_kind
	output logic          m_axis_tlast
);
	import rwdl_pkg::*;

	rec_t             rec_q;
	logic [CNT_W-1:0] idx_q;
	logic             busy_q;
	logic             last;
	logic             done;

	assign last          = (idx_q == (rec_q.cnt - CNT_W'(1)));
	assign done          = busy_q && m_axis_tready && last;
	assign can_load      = !busy_q || done;
	assign m_axis_tvalid = busy_q;
	assign m_axis_tdata  = rec_q.bytes[idx_q];
	assign m_axis_tuser  = rec_q.kind;
	assign m_axis_tlast  = last;

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && m_axis_tready) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

endmodule

### hw/rtl/register_write_delta_logger_core.sv
// Top level: access pipeline, delta encoding and last-logged-time register.
//
// Input stream s_axis carries one bus access per transfer: tuser is the access
// kind (0 read, 1 write), tdata holds the register address, the write byte and
// the 32-bit timestamp. Output stream m_axis carries result bytes: tuser is 0
// for a log byte and 1 for read data, tlast marks the final byte of an access.
// A logged write gives 3, 5 or 7 bytes (delta, address, old XOR new), a read
// gives one byte, a write timestamped before the last logged one gives none.
// An access passes the access stage, then the record register. Throughput: one
// access per cycle for reads and silent writes while m_axis does not stall;
// logged writes go at the pace of the single byte-wide output serializer.
// While a record drains the input can take one more access into the one-entry
// access stage; it and the record register decouple the two sides. A stall on
// m_axis holds the current byte and backs up into s_axis after both stages fill.
// Reset clears the last logged time and the shadow valid bits, so the shadow
// reads as all zero at once; there is no clearing pass.
module register_write_delta_logger_core #(
	parameter int REG_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [7:0] reg_addr, [15:8] write_data, [47:16] now_time
	input  logic        s_axis_tuser,   // [0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] result_byte
	output logic        m_axis_tuser,   // [0] result_kind
	output logic        m_axis_tlast
);
	import rwdl_pkg::*;

	localparam int AW        = $clog2(REG_COUNT);
	localparam int MOD_STEPS = 255 / REG_COUNT;

	function automatic logic [AW-1:0] slot_of(input logic [7:0] a);
		logic [8:0] v;
		v = {1'b0, a};
		for (int i = 0; i < MOD_STEPS; i++) begin
			if (v >= 9'(REG_COUNT)) v = v - 9'(REG_COUNT);
		end
		return v[AW-1:0];
	endfunction

	logic          in_acc;
	logic [7:0]    in_addr;
	logic [7:0]    in_data;
	logic [31:0]   in_now;
	logic [AW-1:0] in_slot;

	logic          valid_s1;
	logic          func_s1;
	logic [7:0]    addr_s1;
	logic [7:0]    data_s1;
	logic [31:0]   now_s1;
	logic [AW-1:0] slot_s1;

	logic [31:0]   last_time_q;
	logic [7:0]    old_byte;
	logic [32:0]   diff_full;
	logic [31:0]   delta;
	logic          log_ok;
	logic          is_write;
	logic          need_rec;
	logic [7:0]    xor_byte;
	logic          s1_go;
	logic          emit_ready;
	logic          emit_load;
	rec_t          rec;

	assign in_addr = s_axis_tdata[7:0];
	assign in_data = s_axis_tdata[15:8];
	assign in_now  = s_axis_tdata[47:16];
	assign in_slot = slot_of(in_addr);
	assign in_acc  = s_axis_tvalid && s_axis_tready;

	rwdl_shadow #(
		.REG_COUNT(REG_COUNT)
	) u_shadow (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (in_slot),
		.rd_data (old_byte),
		.wr_en   (s1_go && is_write),
		.wr_addr (slot_s1),
		.wr_data (data_s1)
	);

	// borrow of the subtraction says the write lies in the past
	assign diff_full = {1'b0, now_s1} - {1'b0, last_time_q};
	assign delta     = diff_full[31:0];
	assign log_ok    = !diff_full[32];
	assign is_write  = (func_s1 == FUNC_WRITE);
	assign need_rec  = !is_write || log_ok;
	assign xor_byte  = old_byte ^ data_s1;

	assign s1_go         = valid_s1 && (!need_rec || emit_ready);
	assign emit_load     = s1_go && need_rec;
	assign s_axis_tready = !valid_s1 || s1_go;

	always_comb begin
		rec      = '0;
		rec.kind = KIND_LOG;
		if (!is_write) begin
			rec.kind     = KIND_READ;
			rec.cnt      = LEN_READ;
			rec.bytes[0] = old_byte;
		end else if (delta < {24'h0, ESC16}) begin
			rec.cnt      = LEN_SHORT;
			rec.bytes[0] = delta[7:0];
			rec.bytes[1] = addr_s1;
			rec.bytes[2] = xor_byte;
		end else if (delta <= D16_MAX) begin
			rec.cnt      = LEN_D16;
			rec.bytes[0] = ESC16;
			rec.bytes[1] = delta[15:8];
			rec.bytes[2] = delta[7:0];
			rec.bytes[3] = addr_s1;
			rec.bytes[4] = xor_byte;
		end else begin
			rec.cnt      = LEN_D32;
			rec.bytes[0] = ESC32;
			rec.bytes[1] = delta[31:24];
			rec.bytes[2] = delta[23:16];
			rec.bytes[3] = delta[15:8];
			rec.bytes[4] = delta[7:0];
			rec.bytes[5] = addr_s1;
			rec.bytes[6] = xor_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1 <= s_axis_tuser;
			addr_s1 <= in_addr;
			data_s1 <= in_data;
			now_s1  <= in_now;
			slot_s1 <= in_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			last_time_q <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go && is_write && log_ok) begin
				last_time_q <= now_s1;
			end
		end
	end

	rwdl_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (emit_load),
		.rec           (rec),
		.can_load      (emit_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_time_update: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && is_write && log_ok) |=> (last_time_q == $past(now_s1)))
		else $error("last logged time not updated by a logged write");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |=> (valid_s1 && $stable(now_s1) && $stable(slot_s1)))
		else $error("stalled access lost or changed");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |-> emit_ready)
		else $error("record loaded while serializer busy");

	a_past_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_write && !log_ok) |-> (s1_go && !emit_load))
		else $error("write in the past did not retire silently");

endmodule
